// ===== rtl/depth_sort_draw_order_macros.svh =====
// Assertion helpers used by dsdo_ctrl.
`ifndef DEPTH_SORT_DRAW_ORDER_MACROS_SVH
`define DEPTH_SORT_DRAW_ORDER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define DSDO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsdo assertion failed");

// Next-cycle implication, held off during reset.
`define DSDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsdo assertion failed");

`endif

// ===== rtl/dsdo_pkg.sv =====
package dsdo_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  localparam int TAG_W  = 16;
  localparam int POS_W  = 32;
  localparam int KEY_W  = 64;
  localparam int WORD_W = TAG_W + KEY_W;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_RENDER = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_Z    = 2'd0,
    MODE_SQ   = 2'd1,
    MODE_AXIS = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_POS_X  = 3'd1,
    REG_POS_Y  = 3'd2,
    REG_POS_Z  = 3'd3,
    REG_DIR_X  = 3'd4,
    REG_DIR_Y  = 3'd5,
    REG_DIR_Z  = 3'd6,
    REG_UNUSED = 3'd7
  } reg_e;

  typedef struct packed {
    logic       load;
    logic       set_drop;
    logic       clear;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] axis;
    logic       write;
    logic       render_start;
    logic       scan_start;
    logic       scan_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic out_fire;
    logic out_last;
  } status_t;

endpackage

// ===== rtl/depth_sort_draw_order.sv =====
// Add: from acceptance to the next ready, one axis product per cycle on the
// shared 33x33 multiplier, then the store write.
// Render of n elements: each word takes a selection pass over the store's
// single read port, then is loaded into the output register and handed off.
// Clear, unknown kind and empty render: ready again on the next cycle.
// Reset (rst_ni low, asynchronous) empties the store and restores the registers.
module depth_sort_draw_order import dsdo_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,  // element_tag, pos_x, pos_y, pos_z
  input  logic [1:0]    s_axis_tuser,  // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata,  // out_tag, depth_key
  output logic          m_axis_tlast,
  output logic          m_axis_tuser,  // overflowed
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  cmd_t             cmd;
  status_t          status;
  logic [TAG_W-1:0] out_tag;
  logic [KEY_W-1:0] out_key;

  // Registers change only while no word is being worked on or offered, so a
  // key is always computed with the settings seen when its word was taken.
  assign cfg_ready_o = s_axis_tready && !s_axis_tvalid;

  dsdo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsdo_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_tag_i    (s_axis_tdata[15:0]),
    .in_pos_x_i  (s_axis_tdata[47:16]),
    .in_pos_y_i  (s_axis_tdata[79:48]),
    .in_pos_z_i  (s_axis_tdata[111:80]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tag_o   (out_tag),
    .out_key_o   (out_key),
    .out_last_o  (m_axis_tlast),
    .out_drop_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_key, out_tag};

endmodule

// ===== rtl/dsdo_ram.sv =====
module dsdo_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsdo_datapath.sv =====
module dsdo_datapath import dsdo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [TAG_W-1:0]  in_tag_i,
  input  logic [POS_W-1:0]  in_pos_x_i,
  input  logic [POS_W-1:0]  in_pos_y_i,
  input  logic [POS_W-1:0]  in_pos_z_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [TAG_W-1:0]  out_tag_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic              out_last_o,
  output logic              out_drop_o
);

  // Configuration registers.
  logic [1:0]       mode_q;
  logic [POS_W-1:0] vp_x_q, vp_y_q, vp_z_q, vd_x_q, vd_y_q, vd_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AXIS;
      vp_x_q <= '0;
      vp_y_q <= '0;
      vp_z_q <= '0;
      vd_x_q <= '0;
      vd_y_q <= '0;
      vd_z_q <= POS_W'(32'h0001_0000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q <= cfg_data_i[1:0];
        REG_POS_X: vp_x_q <= cfg_data_i;
        REG_POS_Y: vp_y_q <= cfg_data_i;
        REG_POS_Z: vp_z_q <= cfg_data_i;
        REG_DIR_X: vd_x_q <= cfg_data_i;
        REG_DIR_Y: vd_y_q <= cfg_data_i;
        REG_DIR_Z: vd_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched element.
  logic [TAG_W-1:0] tag_q;
  logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q   <= in_tag_i;
      pos_x_q <= in_pos_x_i;
      pos_y_q <= in_pos_y_i;
      pos_z_q <= in_pos_z_i;
    end
  end

  // Key unit: one axis product per cycle, registered and accumulated in the next cycle.
  logic [POS_W-1:0]   p_sel, v_sel, d_sel;
  logic signed [32:0] diff, mul_b;
  logic signed [65:0] prod, mult_q;
  logic signed [67:0] acc_q;

  always_comb begin
    case (cmd_i.axis)
      2'd0:    begin p_sel = pos_x_q; v_sel = vp_x_q; d_sel = vd_x_q; end
      2'd1:    begin p_sel = pos_y_q; v_sel = vp_y_q; d_sel = vd_y_q; end
      default: begin p_sel = pos_z_q; v_sel = vp_z_q; d_sel = vd_z_q; end
    endcase
    diff  = $signed({p_sel[POS_W-1], p_sel}) - $signed({v_sel[POS_W-1], v_sel});
    mul_b = (mode_q == MODE_SQ) ? diff : $signed({d_sel[POS_W-1], d_sel});
    prod  = diff * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mult_q <= prod;
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{2{mult_q[65]}}, mult_q};
    end
  end

  logic [KEY_W-1:0] sat_key, new_key;

  always_comb begin
    if (acc_q[67:63] == 5'b00000 || acc_q[67:63] == 5'b11111) begin
      sat_key = acc_q[KEY_W-1:0];
    end else if (acc_q[67]) begin
      sat_key = {1'b1, {(KEY_W-1){1'b0}}};
    end else begin
      sat_key = {1'b0, {(KEY_W-1){1'b1}}};
    end
    case (mode_q)
      MODE_Z:              new_key = {{16{pos_z_q[POS_W-1]}}, pos_z_q, 16'h0000};
      MODE_SQ, MODE_AXIS:  new_key = sat_key;
      default:             new_key = '0;
    endcase
  end

  // Element count and drop flag.
  logic [CW-1:0] count_q;
  logic          drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
    end
  end

  // Element store.
  logic [CW-1:0]     scan_cnt_q;
  logic [WORD_W-1:0] rdata;

  dsdo_ram #(
    .Width (WORD_W),
    .Depth (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({tag_q, new_key}),
    .raddr_i (scan_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Selection scan: each pass finds the largest entry that orders after the
  // one emitted last (descending key, ascending arrival among equal keys).
  logic [KEY_W-1:0] best_key_q, prev_key_q, r_key;
  logic [TAG_W-1:0] best_tag_q, r_tag;
  logic [AW-1:0]    best_idx_q, prev_idx_q, eval_idx;
  logic             found_q, have_prev_q, eligible, better, out_fire;
  logic [CW-1:0]    emitted_q;

  assign r_key    = rdata[KEY_W-1:0];
  assign r_tag    = rdata[WORD_W-1:KEY_W];
  assign eval_idx = AW'(scan_cnt_q - CW'(1));
  assign eligible = !have_prev_q || ($signed(r_key) < $signed(prev_key_q)) ||
                    ((r_key == prev_key_q) && (eval_idx > prev_idx_q));
  assign better   = !found_q || ($signed(r_key) > $signed(best_key_q));
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q  <= '0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      emitted_q   <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
      end else if (cmd_i.scan_en) begin
        scan_cnt_q <= scan_cnt_q + CW'(1);
        if (scan_cnt_q != '0 && eligible && better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.render_start) begin
        have_prev_q <= 1'b0;
        emitted_q   <= '0;
      end else if (out_fire) begin
        have_prev_q <= 1'b1;
        emitted_q   <= emitted_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && scan_cnt_q != '0 && eligible && better) begin
      best_key_q <= r_key;
      best_tag_q <= r_tag;
      best_idx_q <= eval_idx;
    end
    if (out_fire) begin
      prev_key_q <= best_key_q;
      prev_idx_q <= best_idx_q;
    end
  end

  // Output register.
  logic             out_valid_q, out_last_q, out_drop_q;
  logic [TAG_W-1:0] out_tag_q;
  logic [KEY_W-1:0] out_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_tag_q  <= best_tag_q;
      out_key_q  <= best_key_q;
      out_last_q <= (emitted_q + CW'(1)) == count_q;
      out_drop_q <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tag_o   = out_tag_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;

  assign status_o.full      = count_q == CW'(MAX_ELEMENTS);
  assign status_o.empty     = count_q == '0;
  assign status_o.scan_done = scan_cnt_q == count_q;
  assign status_o.out_fire  = out_fire;
  assign status_o.out_last  = out_last_q;

endmodule

// ===== rtl/dsdo_ctrl.sv =====
`include "depth_sort_draw_order_macros.svh"

module dsdo_ctrl import dsdo_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_KEY   = 6'b000010,
    ST_WRITE = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (in_kind_i)
            KIND_ADD: begin
              if (status_i.full) begin
                cmd_o.set_drop = 1'b1;
              end else begin
                state_d = ST_KEY;
                step_d  = 2'd0;
              end
            end
            KIND_RENDER: begin
              if (!status_i.empty) begin
                cmd_o.render_start = 1'b1;
                cmd_o.scan_start   = 1'b1;
                state_d            = ST_SCAN;
              end
            end
            KIND_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_KEY: begin
        cmd_o.mul_en = step_q != 2'd3;
        cmd_o.acc_en = step_q != 2'd0;
        cmd_o.axis   = step_q;
        step_d       = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.out_fire) begin
          if (status_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `DSDO_ASSERT_IMPL(a_write_not_full, state_q == ST_WRITE, !status_i.full)
  `DSDO_ASSERT_NEXT(a_key_to_write, state_q == ST_KEY && step_q == 2'd3, state_q == ST_WRITE)
  `DSDO_ASSERT_IMPL(a_fire_in_wait, status_i.out_fire, state_q == ST_WAIT)
  `DSDO_ASSERT_NEXT(a_scan_to_load, state_q == ST_SCAN && status_i.scan_done, state_q == ST_LOAD)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dsdo_pkg::*;

  typedef struct {
    logic [15:0] tag;
    logic [63:0] key;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  localparam logic signed [127:0] KEY_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] KEY_MIN = -128'sh8000_0000_0000_0000;
  localparam int STALL_LIMIT = 20000;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata;
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [79:0]   m_axis_tdata;
  logic          m_axis_tlast;
  logic          m_axis_tuser;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i;
  logic [31:0]   cfg_data_i;

  // Software copy of the sorter's state.
  mode_e              mode_q;
  logic signed [31:0] vpos_x, vpos_y, vpos_z, vdir_x, vdir_y, vdir_z;
  logic [15:0]        tags_q [MAX_ELEMENTS];
  logic [63:0]        keys_q [MAX_ELEMENTS];
  int                 count_q;
  logic               dropped_q;

  sorted_word_t pending_words [$];
  int           mismatches;
  int           stall_cycles;
  bit           idle_on;

  depth_sort_draw_order u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] depth_of(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    logic signed [33:0]  dx, dy, dz;
    logic signed [127:0] acc;
    dx = $signed(px) - vpos_x;
    dy = $signed(py) - vpos_y;
    dz = $signed(pz) - vpos_z;
    case (mode_q)
      MODE_Z: depth_of = {{16{pz[31]}}, pz, 16'h0};
      MODE_SQ: begin
        acc = dx * dx + dy * dy + dz * dz;
        depth_of = (acc > KEY_MAX) ? KEY_MAX[63:0] : acc[63:0];
      end
      MODE_AXIS: begin
        acc = dx * vdir_x + dy * vdir_y + dz * vdir_z;
        if (acc > KEY_MAX) depth_of = KEY_MAX[63:0];
        else if (acc < KEY_MIN) depth_of = KEY_MIN[63:0];
        else depth_of = acc[63:0];
      end
      default: depth_of = '0;
    endcase
  endfunction

  // Stable sort by descending signed key; expected words go on the queue.
  task automatic predict_render();
    int order [MAX_ELEMENTS];
    int j;
    sorted_word_t w;
    for (int i = 0; i < count_q; i++) begin
      j = i;
      while (j > 0 && $signed(keys_q[i]) > $signed(keys_q[order[j-1]])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < count_q; i++) begin
      w.tag  = tags_q[order[i]];
      w.key  = keys_q[order[i]];
      w.last = (i == count_q - 1);
      w.ovf  = dropped_q;
      pending_words.push_back(w);
    end
  endtask

  task automatic apply_item(kind_e kind, logic [15:0] tag, logic [31:0] px,
                            logic [31:0] py, logic [31:0] pz);
    case (kind)
      KIND_ADD:
        if (count_q < MAX_ELEMENTS) begin
          tags_q[count_q] = tag;
          keys_q[count_q] = depth_of(px, py, pz);
          count_q++;
        end else begin
          dropped_q = 1'b1;
        end
      KIND_RENDER: predict_render();
      KIND_CLEAR: begin
        count_q = 0;
        dropped_q = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic random_gap();
    if (idle_on && $urandom_range(99) < 34)
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(kind_e kind, logic [15:0] tag, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pz);
    random_gap();
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {pz, py, px, tag};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(kind, tag, px, py, pz);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(reg_e index, logic [31:0] value);
    random_gap();
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_MODE:  mode_q = mode_e'(value[1:0]);
      REG_POS_X: vpos_x = value;
      REG_POS_Y: vpos_y = value;
      REG_POS_Z: vpos_z = value;
      REG_DIR_X: vdir_x = value;
      REG_DIR_Y: vdir_y = value;
      REG_DIR_Z: vdir_z = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] any_pos();
    case ($urandom_range(9))
      0: any_pos = 32'h8000_0000;
      1: any_pos = 32'h7FFF_FFFF;
      2: any_pos = '0;
      3, 4: any_pos = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: any_pos = $urandom;
    endcase
  endfunction

  task automatic add_random();
    send_item(KIND_ADD, 16'($urandom), any_pos(), any_pos(), any_pos());
  endtask

  task automatic test_defaults();
    send_item(KIND_RENDER, '0, '0, '0, '0);   // empty store
    send_item(KIND_ADD, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_item(KIND_ADD, 16'h0000, '0, '0, 32'h8000_0000);
    send_item(KIND_ADD, 16'h1234, '0, '0, 32'h0001_0000);   // ties with first
    send_item(KIND_NONE, 16'hAAAA, '1, '1, '1);
    send_item(KIND_RENDER, '0, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0, '0);
    send_item(KIND_RENDER, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_modes();
    write_reg(REG_POS_X, 32'h8000_0000);
    write_reg(REG_POS_Y, 32'h8000_0000);
    write_reg(REG_POS_Z, 32'h8000_0000);
    write_reg(REG_DIR_X, 32'h8000_0000);
    write_reg(REG_DIR_Y, 32'h8000_0000);
    write_reg(REG_DIR_Z, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, m);
      send_item(KIND_ADD, 16'(m), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(KIND_ADD, 16'(m + 8), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(KIND_ADD, 16'(m + 16), 32'h7FFF_FFFF, 32'h8000_0000, '0);
      send_item(KIND_RENDER, '0, '0, '0, '0);
      send_item(KIND_CLEAR, '0, '0, '0, '0);
      drain();
    end
    write_reg(REG_POS_X, 32'h7FFF_FFFF);
    write_reg(REG_POS_Y, 32'h7FFF_FFFF);
    write_reg(REG_POS_Z, 32'h7FFF_FFFF);
    write_reg(REG_DIR_Z, 32'h8000_0000);
    write_reg(REG_MODE, MODE_AXIS);
    send_item(KIND_ADD, 16'h0F0F, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_RENDER, '0, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_full_store();
    for (int i = 0; i < MAX_ELEMENTS + 2; i++) add_random();
    send_item(KIND_RENDER, '0, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0, '0);
    send_item(KIND_ADD, 16'h5A5A, '0, '0, '0);
    send_item(KIND_RENDER, '0, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_random();
    int sent;
    int round;
    sent = 0;
    round = 0;
    while (sent < 125) begin
      idle_on = !(round >= 3 && round < 7);
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(3) == 0) write_reg(REG_MODE, $urandom_range(3));
          else write_reg(reg_e'($urandom_range(7, 1)), any_pos());
        end
      end
      if ($urandom_range(99) < 70) begin
        send_item(KIND_CLEAR, '0, '0, '0, '0);
        sent++;
      end
      repeat (($urandom_range(99) < 4) ? $urandom_range(70, 60) : $urandom_range(12)) begin
        add_random();
        sent++;
        if ($urandom_range(99) < 3) send_item(KIND_NONE, 16'($urandom), $urandom,
                                              $urandom, $urandom);
      end
      repeat ($urandom_range(2, 1)) begin
        send_item(KIND_RENDER, 16'($urandom), $urandom, $urandom, $urandom);
        sent++;
      end
      drain();
      round++;
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk_i)
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: tag %h key %h",
                                       m_axis_tdata[15:0], m_axis_tdata[79:16]);
      end else begin
        sorted_word_t w;
        w = pending_words.pop_front();
        if (m_axis_tdata[15:0] !== w.tag || m_axis_tdata[79:16] !== w.key ||
            m_axis_tlast !== w.last || m_axis_tuser !== w.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tag %h key %h last %b ovf %b, got %h %h %b %b",
                     w.tag, w.key, w.last, w.ovf, m_axis_tdata[15:0],
                     m_axis_tdata[79:16], m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[depth_sort_draw_order] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    m_axis_tready = 1'b0;
    stall_cycles = 0;
    mismatches = 0;
    idle_on = 1'b1;
    mode_q = MODE_AXIS;
    vpos_x = '0;
    vpos_y = '0;
    vpos_z = '0;
    vdir_x = '0;
    vdir_y = '0;
    vdir_z = 32'sd65536;
    count_q = 0;
    dropped_q = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_modes();
    test_full_store();
    test_random();
    drain();
    if (mismatches == 0 && pending_words.size() == 0)
      $display("[depth_sort_draw_order] OK");
    else
      $display("[depth_sort_draw_order] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dsdo_pkg.sv
rtl/dsdo_ram.sv
rtl/dsdo_datapath.sv
rtl/dsdo_ctrl.sv
rtl/depth_sort_draw_order.sv
bench/tb.sv
